FILE: sv/u8u16_pkg.sv
`default_nettype none

package u8u16_pkg;

    localparam int BYTE_W         = 8;
    localparam int UNIT_W         = 16;
    localparam int CP_W           = 21;
    localparam int CAP_W          = 20;
    localparam int CNT_OUT_W      = 20;
    localparam int SEQ_W          = 3;
    localparam int REM_W          = 2;
    localparam int COUNT_BITS_DEF = 20;
    localparam int OUT_DATA_W     = 40;

    localparam logic [CAP_W-1:0]  CAP_RESET  = 20'hFFFFF;
    localparam logic [UNIT_W-1:0] REPL_CHAR  = 16'hFFFD;
    localparam logic [CP_W-1:0]   CP_MAX     = 21'h10FFFF;
    localparam logic [CP_W-1:0]   BMP_MAX    = 21'h00FFFF;
    localparam logic [CP_W-1:0]   SUPP_BASE  = 21'h010000;
    localparam logic [UNIT_W-1:0] HI_SURR    = 16'hD800;
    localparam logic [UNIT_W-1:0] LO_SURR    = 16'hDC00;
    // cp[20:11] of any surrogate value (0xD800..0xDFFF)
    localparam logic [9:0]        SURR_TAG   = 10'h01B;

    // Open-sequence state carried between bytes
    typedef struct packed {
        logic [CP_W-1:0]  point;
        logic [SEQ_W-1:0] seq_len;
        logic [REM_W-1:0] remain;
    } seq_state_t;

    // One UTF-16 unit ready for the output channel
    typedef struct packed {
        logic [UNIT_W-1:0]    unit;
        logic                 repl;
        logic [CNT_OUT_W-1:0] count;
    } unit_slot_t;

    // All units caused by one byte; slot 0 goes out first
    typedef struct packed {
        logic [1:0]            n;
        unit_slot_t [1:0]      slot;
    } unit_bundle_t;

endpackage

`default_nettype wire

FILE: sv/utf8_to_utf16_transcoder_unit.sv
// UTF-8 to UTF-16 transcoder.
// Input stream (s_axis_*): one UTF-8 byte per transfer in tdata[7:0]; tlast
// marks the last byte of a string and closes every open sequence afterward.
// Output stream (m_axis_*): one UTF-16 code unit per transfer. tdata holds
// the unit in [15:0] and the running unit count of the string in [35:16];
// tuser flags a U+FFFD made by an encoding error; tlast marks the last unit
// caused by one input byte. Bytes that cause no unit produce no transfer.
// cfg_we/cfg_wdata set the destination capacity in units (reset 0xFFFFF);
// units beyond it are dropped, a surrogate pair whole. Write it only idle.
// An accepted byte waits in the input register, is decoded into the result
// register, and its first unit transfers from there.
// Throughput: one byte per cycle while each byte gives at most one unit and
// the receiver is ready; a byte giving two units holds the output register
// until both have gone, as the result register drains one unit per transfer.
// Reset clears the open sequence, the unit count and both registers' valid
// state. When the receiver stalls, the result register holds and the input
// register fills, then s_axis_tready drops; nothing is lost.
`default_nettype none

module utf8_to_utf16_transcoder_unit #(
    parameter int COUNT_BITS = u8u16_pkg::COUNT_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // configuration: capacity_units
    input  wire logic                               cfg_we,
    input  wire logic [u8u16_pkg::CAP_W-1:0]        cfg_wdata,
    // tdata: in_byte[7:0]
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [u8u16_pkg::BYTE_W-1:0]       s_axis_tdata,
    input  wire logic                               s_axis_tlast,
    // tdata: code_unit[15:0], units_written[35:16], zero[39:36]
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [u8u16_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    // tuser: replaced
    output logic                                    m_axis_tuser,
    output logic                                    m_axis_tlast
);
    import u8u16_pkg::*;

    // Configuration register
    logic [CAP_W-1:0] cap_reg;

    // Input register
    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_eos_reg;

    // String state
    seq_state_t              st_reg, st_next;
    logic [COUNT_BITS-1:0]   idx_reg, idx_next;

    unit_bundle_t bundle;
    unit_slot_t   out_slot;
    logic         can_load;
    logic         advance;
    logic         out_load;
    logic         in_take;

    // Advance the byte into the result register when it is free, or at once
    // when the byte produces nothing to hold.
    assign advance       = in_valid_reg && ((bundle.n == 2'd0) || can_load);
    // Load the result register only with units; a byte that yields none
    // must leave pending units in place
    assign out_load      = advance && (bundle.n != 2'd0);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    u8u16_decode #(
        .COUNT_BITS (COUNT_BITS)
    ) u_decode (
        .in_byte  (in_byte_reg),
        .eos      (in_eos_reg),
        .st       (st_reg),
        .idx      (idx_reg),
        .cap      (cap_reg),
        .st_next  (st_next),
        .idx_next (idx_next),
        .bundle   (bundle)
    );

    u8u16_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .bundle    (bundle),
        .can_load  (can_load),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_slot  (out_slot),
        .out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-UNIT_W-CNT_OUT_W){1'b0}}, out_slot.count, out_slot.unit};
    assign m_axis_tuser = out_slot.repl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg      <= CAP_RESET;
            in_valid_reg <= 1'b0;
            st_reg       <= '0;
            idx_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_wdata;
            end
            if (in_take)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                st_reg  <= st_next;
                idx_reg <= idx_next;
            end
        end
    end

    // Hold the byte payload; no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_axis_tdata;
            in_eos_reg  <= s_axis_tlast;
        end
    end

endmodule

`default_nettype wire

FILE: sv/u8u16_decode.sv
`default_nettype none

module u8u16_decode #(
    parameter int COUNT_BITS = u8u16_pkg::COUNT_BITS_DEF
) (
    input  wire logic [u8u16_pkg::BYTE_W-1:0] in_byte,
    input  wire logic                         eos,
    input  wire u8u16_pkg::seq_state_t        st,
    input  wire logic [COUNT_BITS-1:0]        idx,
    input  wire logic [u8u16_pkg::CAP_W-1:0]  cap,
    output u8u16_pkg::seq_state_t             st_next,
    output logic [COUNT_BITS-1:0]             idx_next,
    output u8u16_pkg::unit_bundle_t           bundle
);
    import u8u16_pkg::*;

    localparam int CW = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 2;
    localparam logic [CW-1:0] CNT_MAX = {{(CW-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

    logic [CW-1:0] cap_ext, lim, idx_ext, idx1, cnt0, cnt1;

    always_comb
    begin
        logic             cont;
        logic [CP_W-1:0]  shifted;
        logic [REM_W-1:0] rem_dec;
        logic [1:0]       proper;
        logic [SEQ_W-1:0] exp_len;
        logic             bad_point;
        // lead decode
        logic             lead_pt;
        logic [UNIT_W-1:0] lead_cp;
        logic             lead_r;
        seq_state_t       lead_st;
        // points to emit
        logic             p0_v, p0_r, p1_v, p1_r;
        logic [CP_W-1:0]  p0_cp;
        logic [UNIT_W-1:0] p1_cp;
        logic             e0_pair, e0_one, e1;
        logic [CP_W-1:0]  v;
        logic [1:0]       n;

        cont    = (in_byte[7:6] == 2'b10);
        shifted = {st.point[CP_W-7:0], in_byte[5:0]};
        rem_dec = st.remain - 2'd1;

        // expected length of the completed point
        if (shifted <= 21'h00007F)      proper = 2'd0;
        else if (shifted <= 21'h0007FF) proper = 2'd1;
        else if (shifted <= BMP_MAX)    proper = 2'd2;
        else                            proper = 2'd3;
        exp_len   = {1'b0, proper} + 3'd1;
        bad_point = (exp_len != st.seq_len) || (shifted[20:11] == SURR_TAG)
                  || (shifted > CP_MAX);

        // byte taken as a lead byte, from a closed sequence
        lead_pt = 1'b0;
        lead_cp = REPL_CHAR;
        lead_r  = 1'b1;
        lead_st = '0;
        unique casez (in_byte)
            8'b0???????:
            begin
                lead_pt = 1'b1;
                lead_cp = {8'h00, in_byte};
                lead_r  = 1'b0;
            end
            8'b110?????:
            begin
                lead_st.point   = {16'h0000, in_byte[4:0]};
                lead_st.seq_len = 3'd2;
                lead_st.remain  = 2'd1;
            end
            8'b1110????:
            begin
                lead_st.point   = {17'h00000, in_byte[3:0]};
                lead_st.seq_len = 3'd3;
                lead_st.remain  = 2'd2;
            end
            8'b11110???:
            begin
                lead_st.point   = {18'h00000, in_byte[2:0]};
                lead_st.seq_len = 3'd4;
                lead_st.remain  = 2'd3;
            end
            default:
            begin
                lead_pt = 1'b1;
            end
        endcase
        // string ends on an opening lead byte: cut-off sequence
        if (eos && (lead_st.remain != 2'd0))
        begin
            lead_pt = 1'b1;
            lead_cp = REPL_CHAR;
            lead_r  = 1'b1;
            lead_st = '0;
        end

        p0_v    = 1'b0;
        p0_cp   = {5'h00, REPL_CHAR};
        p0_r    = 1'b1;
        p1_v    = 1'b0;
        p1_cp   = lead_cp;
        p1_r    = lead_r;
        st_next = '0;

        if (st.remain == 2'd0)
        begin
            p0_v    = lead_pt;
            p0_cp   = {5'h00, lead_cp};
            p0_r    = lead_r;
            st_next = lead_st;
        end
        else if (!cont)
        begin
            // broken sequence, then the same byte as a lead
            p0_v    = 1'b1;
            p1_v    = lead_pt;
            st_next = lead_st;
        end
        else if (rem_dec == 2'd0)
        begin
            p0_v = 1'b1;
            if (!bad_point)
            begin
                p0_cp = shifted;
                p0_r  = 1'b0;
            end
        end
        else if (eos)
        begin
            p0_v = 1'b1;
        end
        else
        begin
            st_next.point   = shifted;
            st_next.seq_len = st.seq_len;
            st_next.remain  = rem_dec;
        end
        if (eos)
        begin
            st_next = '0;
        end

        // capacity check against the running unit count
        cap_ext = CW'(cap);
        lim     = (cap_ext < CNT_MAX) ? cap_ext : CNT_MAX;
        idx_ext = CW'(idx);
        e0_pair = p0_v && (p0_cp > BMP_MAX) && ((idx_ext + CW'(2)) <= lim);
        e0_one  = p0_v && (p0_cp <= BMP_MAX) && (idx_ext < lim);
        idx1    = idx_ext + CW'({e0_pair, e0_one});
        e1      = p1_v && (idx1 < lim);
        n       = {e0_pair, e0_one} + {1'b0, e1};
        v       = p0_cp - SUPP_BASE;
        cnt0    = idx_ext + CW'(1);
        cnt1    = idx_ext + CW'(2);

        bundle.n             = n;
        bundle.slot[0].repl  = p0_r;
        bundle.slot[0].unit  = p0_cp[UNIT_W-1:0];
        bundle.slot[0].count = cnt0[CNT_OUT_W-1:0];
        bundle.slot[1].repl  = p1_r;
        bundle.slot[1].unit  = p1_cp;
        bundle.slot[1].count = cnt1[CNT_OUT_W-1:0];
        if (e0_pair)
        begin
            bundle.slot[0].unit = HI_SURR | {6'h00, v[19:10]};
            bundle.slot[1].unit = LO_SURR | {6'h00, v[9:0]};
            bundle.slot[1].repl = p0_r;
        end
        else if (!e0_one)
        begin
            // only the lead-byte unit survives
            bundle.slot[0].unit = p1_cp;
            bundle.slot[0].repl = p1_r;
        end

        idx_next = eos ? '0 : COUNT_BITS'(idx_ext + CW'(n));
    end

endmodule

`default_nettype wire

FILE: sv/u8u16_out.sv
`default_nettype none

module u8u16_out (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  wire u8u16_pkg::unit_bundle_t bundle,
    output logic                         can_load,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output u8u16_pkg::unit_slot_t        out_slot,
    output logic                         out_last
);
    import u8u16_pkg::*;

    logic [1:0]  left_reg, left_next;
    unit_slot_t  slot0_reg, slot0_next;
    unit_slot_t  slot1_reg, slot1_next;
    logic        take;

    assign out_valid = (left_reg != 2'd0);
    assign out_last  = (left_reg == 2'd1);
    assign out_slot  = slot0_reg;
    assign take      = out_valid && out_ready;
    assign can_load  = (left_reg == 2'd0) || (out_last && take);

    always_comb
    begin
        left_next  = left_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (load)
        begin
            left_next  = bundle.n;
            slot0_next = bundle.slot[0];
            slot1_next = bundle.slot[1];
        end
        else if (take)
        begin
            // advance the second unit into the head slot
            left_next  = left_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= 2'd0;
        end
        else
        begin
            left_reg <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

endmodule

`default_nettype wire
